>>> hdl/qloe_pkg.sv
// shared constants, types and helpers for the quaternion log orientation error core
package qloe_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ISQ_IN_W = 50;
    localparam int ISQ_OUT_W = ISQ_IN_W / 2;
    localparam int MAG_W = 23;
    localparam int DIV_Q_W = 16;
    localparam logic [15:0] THR_RESET = 16'd66;

    // atan(2^-i) in Q2.30, rounded to nearest
    localparam logic [29:0] ATAN_TAB [32] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
        30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
        30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
    };

    typedef struct packed {
        logic [3:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  degen;
        logic [47:0]           vv;
        logic [48:0]           qq;
    } head_t;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  degen;
        logic                  taylor;
        logic [ISQ_OUT_W-1:0]  vn;
        logic [ISQ_OUT_W-1:0]  qn;
    } side_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       taylor;
        logic       degen;
        logic       zero;
    } ctl_t;

    // eight long-division steps by six: returns {quotient byte, remainder}
    function automatic logic [10:0] div6_byte(input logic [2:0] rem_in, input logic [7:0] bits);
        logic [3:0] r;
        logic [7:0] q;
        r = {1'b0, rem_in};
        q = '0;
        for (int i = 7; i >= 0; i--)
        begin
            r = {r[2:0], bits[i]};
            if (r >= 4'd6)
            begin
                r = r - 4'd6;
                q[i] = 1'b1;
            end
        end
        return {q, r[2:0]};
    endfunction

endpackage

>>> hdl/qloe_isqrt.sv
// pipelined floor integer square root, one result bit per stage
module qloe_isqrt #(
    parameter int IN_W = qloe_pkg::ISQ_IN_W
) (
    input  logic              clk,
    input  logic              en,
    input  logic [IN_W-1:0]   radicand,
    output logic [IN_W/2-1:0] root
);

    localparam int RW = IN_W / 2;
    localparam int REM_W = RW + 3;

    logic [REM_W-1:0] rem_reg  [RW];
    logic [RW-1:0]    root_reg [RW];
    logic [IN_W-1:0]  val_reg  [RW];

    for (genvar s = 0; s < RW; s++)
    begin : g_step
        logic [REM_W-1:0] rem_prev;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic [RW-1:0]    root_prev;
        logic [IN_W-1:0]  val_prev;

        if (s == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign val_prev  = radicand;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[s-1];
            assign root_prev = root_reg[s-1];
            assign val_prev  = val_reg[s-1];
        end

        assign rem_sh = {rem_prev[REM_W-3:0], val_prev[IN_W-1 -: 2]};
        assign trial  = {{(REM_W-RW-2){1'b0}}, root_prev, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_sh >= trial)
                begin
                    rem_reg[s]  <= rem_sh - trial;
                    root_reg[s] <= {root_prev[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s]  <= rem_sh;
                    root_reg[s] <= {root_prev[RW-2:0], 1'b0};
                end
                val_reg[s] <= val_prev << 2;
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

>>> hdl/quaternion_log_orientation_error_core.sv
// top level: relative quaternion, normalization, cordic angle and scaled rotation vector
// Fully pipelined: one transaction enters per cycle unless the result side
// stalls. The depth comes from the 25-step square root pipelines for |vec|
// and |p|, one stage per CORDIC iteration, and the 16-step restoring divider
// that scales the vector. A stall on the result side freezes the whole pipeline,
// so nothing is dropped or repeated. small_angle_threshold should only be
// written while the core is empty.
module quaternion_log_orientation_error_core #(
    parameter int CORDIC_STAGES = qloe_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] desired_w,
    input  logic signed [15:0] desired_x,
    input  logic signed [15:0] desired_y,
    input  logic signed [15:0] desired_z,
    input  logic signed [15:0] current_w,
    input  logic signed [15:0] current_x,
    input  logic signed [15:0] current_y,
    input  logic signed [15:0] current_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] error_x,
    output logic signed [15:0] error_y,
    output logic signed [15:0] error_z,
    output logic               small_angle,
    output logic               degenerate
);

    localparam int MW = qloe_pkg::MAG_W;
    localparam int ISQ_W = qloe_pkg::ISQ_OUT_W;
    localparam int HEAD_LAT = ISQ_W;
    localparam int POST_LAT = 8;
    localparam int DIV_LAT = qloe_pkg::DIV_Q_W;
    localparam int LAT = 7 + HEAD_LAT + 1 + CORDIC_STAGES + POST_LAT + 2 + DIV_LAT + 1;
    localparam int P0_IDX = 7 + HEAD_LAT + 1 + CORDIC_STAGES;
    localparam int M2_IDX = P0_IDX + POST_LAT + 1;

    logic           en;
    logic [LAT-1:0] valid_reg;
    logic [15:0]    thr_reg;

    assign en        = ~valid_reg[LAT-1] | out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            thr_reg   <= qloe_pkg::THR_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            if (en)
            begin
                valid_reg <= {valid_reg[LAT-2:0], in_valid};
            end
        end
    end

    // stage 1: the sixteen partial products
    logic signed [31:0] prod_reg [16];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0]  <= desired_w * current_w;
            prod_reg[1]  <= desired_x * current_x;
            prod_reg[2]  <= desired_y * current_y;
            prod_reg[3]  <= desired_z * current_z;
            prod_reg[4]  <= desired_w * current_x;
            prod_reg[5]  <= current_w * desired_x;
            prod_reg[6]  <= desired_y * current_z;
            prod_reg[7]  <= desired_z * current_y;
            prod_reg[8]  <= desired_w * current_y;
            prod_reg[9]  <= current_w * desired_y;
            prod_reg[10] <= desired_z * current_x;
            prod_reg[11] <= desired_x * current_z;
            prod_reg[12] <= desired_w * current_z;
            prod_reg[13] <= current_w * desired_z;
            prod_reg[14] <= desired_x * current_y;
            prod_reg[15] <= desired_y * current_x;
        end
    end

    // stage 2: desired times conjugate of current
    logic signed [33:0] p_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2])
                      + 34'(prod_reg[3]);
            p_reg[1] <= 34'(prod_reg[5]) - 34'(prod_reg[4]) - 34'(prod_reg[6])
                      + 34'(prod_reg[7]);
            p_reg[2] <= 34'(prod_reg[9]) - 34'(prod_reg[8]) - 34'(prod_reg[10])
                      + 34'(prod_reg[11]);
            p_reg[3] <= 34'(prod_reg[13]) - 34'(prod_reg[12]) - 34'(prod_reg[14])
                      + 34'(prod_reg[15]);
        end
    end

    // stage 3: magnitudes, signs after hemisphere flip, or of all magnitudes
    logic [3:0][32:0] mag3_next;
    logic [3:0][32:0] mag3_reg;
    logic [2:0]       neg3_next;
    logic [2:0]       neg3_reg;
    logic [32:0]      or3_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mag3_next[i] = p_reg[i][33] ? 33'(-p_reg[i]) : 33'(p_reg[i]);
        end
        for (int i = 1; i < 4; i++)
        begin
            neg3_next[i-1] = (p_reg[i][33] != p_reg[0][33]) && (p_reg[i] != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag3_reg <= mag3_next;
            neg3_reg <= neg3_next;
            or3_reg  <= mag3_next[0] | mag3_next[1] | mag3_next[2] | mag3_next[3];
        end
    end

    // stage 4: leading one of the largest magnitude
    logic [5:0]       k4_next;
    logic [5:0]       k4_reg;
    logic [3:0][32:0] mag4_reg;
    logic [2:0]       neg4_reg;
    logic             degen4_reg;

    always_comb
    begin
        k4_next = '0;
        for (int i = 0; i < 33; i++)
        begin
            if (or3_reg[i])
            begin
                k4_next = 6'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k4_reg     <= k4_next;
            mag4_reg   <= mag3_reg;
            neg4_reg   <= neg3_reg;
            degen4_reg <= (or3_reg == '0);
        end
    end

    // stage 5: block scaling so the largest lies in [2^22, 2^23)
    logic [3:0][32:0]   sh5_next;
    logic [3:0][MW-1:0] mag5_reg;
    logic [2:0]         neg5_reg;
    logic               degen5_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (k4_reg > 6'd22)
            begin
                sh5_next[i] = mag4_reg[i] >> (k4_reg - 6'd22);
            end
            else
            begin
                sh5_next[i] = mag4_reg[i] << (6'd22 - k4_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                mag5_reg[i] <= sh5_next[i][MW-1:0];
            end
            neg5_reg   <= neg4_reg;
            degen5_reg <= degen4_reg;
        end
    end

    // stage 6: squares
    logic [45:0]        sq6_reg [4];
    logic [3:0][MW-1:0] mag6_reg;
    logic [2:0]         neg6_reg;
    logic               degen6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                sq6_reg[i] <= mag5_reg[i] * mag5_reg[i];
            end
            mag6_reg   <= mag5_reg;
            neg6_reg   <= neg5_reg;
            degen6_reg <= degen5_reg;
        end
    end

    // stage 7: squared norms
    logic [47:0]        vv7_reg;
    logic [48:0]        qq7_reg;
    logic [3:0][MW-1:0] mag7_reg;
    logic [2:0]         neg7_reg;
    logic               degen7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vv7_reg <= 48'(sq6_reg[1]) + 48'(sq6_reg[2]) + 48'(sq6_reg[3]);
            qq7_reg <= 49'(sq6_reg[0]) + 49'(sq6_reg[1]) + 49'(sq6_reg[2])
                     + 49'(sq6_reg[3]);
            mag7_reg   <= mag6_reg;
            neg7_reg   <= neg6_reg;
            degen7_reg <= degen6_reg;
        end
    end

    // square roots, with the rest of the transaction delayed alongside
    logic [ISQ_W-1:0]      vn;
    logic [ISQ_W-1:0]      qn;
    qloe_pkg::head_t       head_reg [HEAD_LAT];
    qloe_pkg::head_t       head_in;
    qloe_pkg::head_t       head_out;

    qloe_isqrt #(.IN_W(qloe_pkg::ISQ_IN_W)) u_vsqrt (
        .clk      (clk),
        .en       (en),
        .radicand ({2'b00, vv7_reg}),
        .root     (vn)
    );

    qloe_isqrt #(.IN_W(qloe_pkg::ISQ_IN_W)) u_qsqrt (
        .clk      (clk),
        .en       (en),
        .radicand ({1'b0, qq7_reg}),
        .root     (qn)
    );

    always_comb
    begin
        head_in.mag   = mag7_reg;
        head_in.neg   = neg7_reg;
        head_in.degen = degen7_reg;
        head_in.vv    = vv7_reg;
        head_in.qq    = qq7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            head_reg[0] <= head_in;
            for (int i = 1; i < HEAD_LAT; i++)
            begin
                head_reg[i] <= head_reg[i-1];
            end
        end
    end

    assign head_out = head_reg[HEAD_LAT-1];

    // cordic entry, threshold product split in two halves
    logic signed [27:0] c0_x_reg;
    logic signed [27:0] c0_y_reg;
    logic [47:0]        c0_vv_reg;
    logic [40:0]        c0_plo_reg;
    logic [39:0]        c0_phi_reg;
    qloe_pkg::side_t    c0_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_x_reg           <= signed'(28'(head_out.mag[0]));
            c0_y_reg           <= signed'(28'(vn));
            c0_vv_reg          <= head_out.vv;
            c0_plo_reg         <= thr_reg * head_out.qq[24:0];
            c0_phi_reg         <= thr_reg * head_out.qq[48:25];
            c0_side_reg.mag    <= {head_out.mag[3], head_out.mag[2], head_out.mag[1]};
            c0_side_reg.neg    <= head_out.neg;
            c0_side_reg.degen  <= head_out.degen;
            c0_side_reg.taylor <= 1'b0;
            c0_side_reg.vn     <= vn;
            c0_side_reg.qn     <= qn;
        end
    end

    // cordic vectoring, one iteration per stage
    logic signed [27:0] cx_reg [CORDIC_STAGES];
    logic signed [27:0] cy_reg [CORDIC_STAGES];
    logic signed [33:0] cz_reg [CORDIC_STAGES];
    qloe_pkg::side_t    cs_reg [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        logic signed [27:0] x_in;
        logic signed [27:0] y_in;
        logic signed [27:0] xs;
        logic signed [27:0] ys;
        logic signed [33:0] z_in;
        logic signed [33:0] ang;
        qloe_pkg::side_t    s_in;

        if (i == 0)
        begin : g_first
            assign x_in = c0_x_reg;
            assign y_in = c0_y_reg;
            assign z_in = '0;
            always_comb
            begin
                s_in        = c0_side_reg;
                s_in.taylor = 66'({c0_vv_reg, 16'b0})
                            < (66'({c0_phi_reg, 25'b0}) + 66'(c0_plo_reg));
            end
        end
        else
        begin : g_next
            assign x_in = cx_reg[i-1];
            assign y_in = cy_reg[i-1];
            assign z_in = cz_reg[i-1];
            assign s_in = cs_reg[i-1];
        end

        assign xs  = x_in >>> i;
        assign ys  = y_in >>> i;
        assign ang = signed'({4'b0000, qloe_pkg::ATAN_TAB[i]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_in[27])
                begin
                    cx_reg[i] <= x_in + ys;
                    cy_reg[i] <= y_in - xs;
                    cz_reg[i] <= z_in + ang;
                end
                else
                begin
                    cx_reg[i] <= x_in - ys;
                    cy_reg[i] <= y_in + xs;
                    cz_reg[i] <= z_in - ang;
                end
                cs_reg[i] <= s_in;
            end
        end
    end

    // theta, then the taylor factor 2*(1 + theta^2/6)
    logic signed [33:0] z_last;
    logic [31:0]        theta_next;
    logic [31:0]        p_theta_reg [POST_LAT];
    qloe_pkg::side_t    p_side_reg  [POST_LAT];
    logic [33:0]        tt_reg;
    logic [39:0]        d6_n_reg [5];
    logic [39:0]        d6_q_reg [5];
    logic [2:0]         d6_r_reg [5];
    logic [33:0]        f_reg;

    assign z_last     = cz_reg[CORDIC_STAGES-1];
    assign theta_next = z_last[33] ? '0 : {z_last[30:0], 1'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_theta_reg[0] <= theta_next;
            p_side_reg[0]  <= cs_reg[CORDIC_STAGES-1];
            for (int i = 1; i < POST_LAT; i++)
            begin
                p_theta_reg[i] <= p_theta_reg[i-1];
                p_side_reg[i]  <= p_side_reg[i-1];
            end
            tt_reg <= p_theta_reg[0][31:15] * p_theta_reg[0][31:15];
            f_reg  <= 34'h080000000 + {d6_q_reg[4][32:0], 1'b0};
        end
    end

    // divide theta^2 by six, a byte per stage
    for (genvar c = 0; c < 5; c++)
    begin : g_div6
        logic [39:0] n_in;
        logic [39:0] q_in;
        logic [2:0]  r_in;
        logic [10:0] res;
        logic [39:0] q_out;

        if (c == 0)
        begin : g_first
            assign n_in = {6'b0, tt_reg};
            assign q_in = '0;
            assign r_in = '0;
        end
        else
        begin : g_next
            assign n_in = d6_n_reg[c-1];
            assign q_in = d6_q_reg[c-1];
            assign r_in = d6_r_reg[c-1];
        end

        assign res = qloe_pkg::div6_byte(r_in, n_in[39-8*c -: 8]);

        always_comb
        begin
            q_out = q_in;
            q_out[39-8*c -: 8] = res[10:3];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d6_n_reg[c] <= n_in;
                d6_q_reg[c] <= q_out;
                d6_r_reg[c] <= res[2:0];
            end
        end
    end

    // numerator and denominator of the three scaled components
    qloe_pkg::side_t sm;
    logic [33:0]     fac;
    logic [56:0]     m1_num_reg [3];
    logic [42:0]     m1_den_reg;
    qloe_pkg::ctl_t  m1_ctl_reg;
    logic [57:0]     m2_n_reg [3];
    logic [42:0]     m2_den_reg;
    qloe_pkg::ctl_t  m2_ctl_reg;

    assign sm  = p_side_reg[POST_LAT-1];
    assign fac = sm.taylor ? f_reg : {2'b00, p_theta_reg[POST_LAT-1]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                m1_num_reg[l] <= fac * sm.mag[l];
                m2_n_reg[l]   <= 58'(m1_num_reg[l]) + 58'(m1_den_reg[42:1]);
            end
            m1_den_reg        <= sm.taylor ? {sm.qn, 18'b0} : {sm.vn, 18'b0};
            m1_ctl_reg.neg    <= sm.neg;
            m1_ctl_reg.taylor <= sm.taylor;
            m1_ctl_reg.degen  <= sm.degen;
            m1_ctl_reg.zero   <= (sm.vn == '0);
            m2_den_reg        <= m1_den_reg;
            m2_ctl_reg        <= m1_ctl_reg;
        end
    end

    // restoring division, one quotient bit per stage
    logic [57:0]    dr_reg [3][DIV_LAT];
    logic [15:0]    dq_reg [3][DIV_LAT];
    logic [42:0]    dd_reg [DIV_LAT];
    qloe_pkg::ctl_t dc_reg [DIV_LAT];

    for (genvar j = 0; j < DIV_LAT; j++)
    begin : g_div
        logic [42:0]    d_in;
        logic [57:0]    trial;
        qloe_pkg::ctl_t c_in;

        if (j == 0)
        begin : g_first
            assign d_in = m2_den_reg;
            assign c_in = m2_ctl_reg;
        end
        else
        begin : g_next
            assign d_in = dd_reg[j-1];
            assign c_in = dc_reg[j-1];
        end

        assign trial = {15'b0, d_in} << (DIV_LAT - 1 - j);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dd_reg[j] <= d_in;
                dc_reg[j] <= c_in;
            end
        end

        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic [57:0] r_in;
            logic [15:0] q_in;

            if (j == 0)
            begin : g_first
                assign r_in = m2_n_reg[l];
                assign q_in = '0;
            end
            else
            begin : g_next
                assign r_in = dr_reg[l][j-1];
                assign q_in = dq_reg[l][j-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (r_in >= trial)
                    begin
                        dr_reg[l][j] <= r_in - trial;
                        dq_reg[l][j] <= {q_in[14:0], 1'b1};
                    end
                    else
                    begin
                        dr_reg[l][j] <= r_in;
                        dq_reg[l][j] <= {q_in[14:0], 1'b0};
                    end
                end
            end
        end
    end

    // output register: sign, saturation and the special cases
    qloe_pkg::ctl_t     oc;
    logic signed [15:0] err_next [3];
    logic signed [15:0] err_reg  [3];
    logic               small_reg;
    logic               degen_reg;

    assign oc = dc_reg[DIV_LAT-1];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (oc.degen || (!oc.taylor && oc.zero))
            begin
                err_next[l] = '0;
            end
            else if (oc.neg[l])
            begin
                err_next[l] = (dq_reg[l][DIV_LAT-1] > 16'd32768) ? 16'sh8000
                            : signed'(16'd0 - dq_reg[l][DIV_LAT-1]);
            end
            else
            begin
                err_next[l] = (dq_reg[l][DIV_LAT-1] > 16'd32767) ? 16'sh7fff
                            : signed'(dq_reg[l][DIV_LAT-1]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                err_reg[l] <= err_next[l];
            end
            small_reg <= oc.taylor && !oc.degen;
            degen_reg <= oc.degen;
        end
    end

    assign error_x     = err_reg[0];
    assign error_y     = err_reg[1];
    assign error_z     = err_reg[2];
    assign small_angle = small_reg;
    assign degenerate  = degen_reg;

    // a degenerate transaction carries no error and no small-angle flag
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> error_x == 0 && error_y == 0 && error_z == 0
        && !small_angle)
        else $error("degenerate result not zero");

    // a stalled pipeline keeps every transaction where it is
    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(valid_reg))
        else $error("pipeline moved during stall");

    // cordic angle stays within the first quadrant plus residual error
    a_theta: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[P0_IDX] && !p_side_reg[0].degen |-> p_theta_reg[0] <= 32'hCC000000)
        else $error("theta out of range");

    // the quotient of every live lane fits the divider's sixteen bits
    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[M2_IDX] && !m2_ctl_reg.degen && (m2_ctl_reg.taylor || !m2_ctl_reg.zero)
        |-> 59'(m2_n_reg[0]) < {m2_den_reg, 16'b0} && 59'(m2_n_reg[1]) < {m2_den_reg, 16'b0}
        && 59'(m2_n_reg[2]) < {m2_den_reg, 16'b0})
        else $error("divider quotient overflow");

endmodule

>>> tb/quaternion_log_orientation_error_core_test.sv
// testbench for the quaternion log orientation error core: predicted error vectors vs dut results
module quaternion_log_orientation_error_core_test;

    typedef struct {
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic signed [15:0] ez;
        logic               taylor;
        logic               degen;
    } err_vec_t;

    localparam int ANGLE_STEPS = qloe_pkg::CORDIC_STAGES_DEF;
    localparam int PIPE_DEPTH = 60 + ANGLE_STEPS;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic in_valid;
    logic in_ready;
    logic signed [15:0] desired_w, desired_x, desired_y, desired_z;
    logic signed [15:0] current_w, current_x, current_y, current_z;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] error_x, error_y, error_z;
    logic small_angle;
    logic degenerate;

    int send_idle_pct;
    int recv_stall_pct;

    quaternion_log_orientation_error_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .desired_w(desired_w), .desired_x(desired_x),
        .desired_y(desired_y), .desired_z(desired_z),
        .current_w(current_w), .current_x(current_x),
        .current_y(current_y), .current_z(current_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .error_x(error_x), .error_y(error_y), .error_z(error_z),
        .small_angle(small_angle), .degenerate(degenerate)
    );

    class log_error_scoreboard;
        err_vec_t pending[$];
        logic [15:0] threshold;
        int fails;

        function new();
            threshold = qloe_pkg::THR_RESET;
            fails = 0;
        endfunction

        static function longint unsigned isqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        static function logic [15:0] round_sat(longint unsigned num, bit neg,
                                               longint unsigned den);
            longint unsigned q;
            q = (num + den / 2) / den;
            if (neg)
                return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
            return (q > 32767) ? 16'h7fff : 16'(q);
        endfunction

        function void note_input(logic signed [15:0] q[8]);
            longint p[4];
            longint unsigned mag[4];
            longint unsigned m, vv, qq, vn, qn, den, f, t, num;
            bit ng[4];
            bit flip;
            bit taylor;
            int rs, ls;
            longint x, y, z, xs, ys, theta;
            err_vec_t e;
            longint dw, dx, dy, dz, cw, cx, cy, cz;
            dw = q[0]; dx = q[1]; dy = q[2]; dz = q[3];
            cw = q[4]; cx = q[5]; cy = q[6]; cz = q[7];
            p[0] = dw*cw + dx*cx + dy*cy + dz*cz;
            p[1] = -dw*cx + cw*dx - (dy*cz - dz*cy);
            p[2] = -dw*cy + cw*dy - (dz*cx - dx*cz);
            p[3] = -dw*cz + cw*dz - (dx*cy - dy*cx);
            flip = p[0] < 0;
            m = 0;
            for (int i = 0; i < 4; i++)
            begin
                ng[i] = ((p[i] < 0) != flip) && p[i] != 0;
                mag[i] = (p[i] < 0) ? longint'(-p[i]) : p[i];
                if (mag[i] > m)
                    m = mag[i];
            end
            e = '{0, 0, 0, 0, 0};
            if (m == 0)
            begin
                e.degen = 1;
                pending.insert(pending.size(), e);
                return;
            end
            rs = 0;
            ls = 0;
            while ((m >> rs) >= (64'd1 << 23))
                rs++;
            while ((m << ls) < (64'd1 << 22))
                ls++;
            for (int i = 0; i < 4; i++)
                mag[i] = (mag[i] >> rs) << ls;
            vv = mag[1]*mag[1] + mag[2]*mag[2] + mag[3]*mag[3];
            qq = vv + mag[0]*mag[0];
            vn = isqrt(vv);
            qn = isqrt(qq);
            taylor = (vv << 16) < longint'(threshold) * qq;
            x = mag[0];
            y = vn;
            z = 0;
            for (int i = 0; i < ANGLE_STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys; y = y - xs; z += qloe_pkg::ATAN_TAB[i];
                end
                else
                begin
                    x = x - ys; y = y + xs; z -= qloe_pkg::ATAN_TAB[i];
                end
            end
            if (z < 0)
                z = 0;
            theta = 2 * z;
            if (taylor)
            begin
                t = longint'(theta) >> 15;
                f = 2 * ((64'd1 << 30) + (t * t) / 6);
                den = qn << 18;
                e.ex = round_sat(f * mag[1], ng[1], den);
                e.ey = round_sat(f * mag[2], ng[2], den);
                e.ez = round_sat(f * mag[3], ng[3], den);
            end
            else if (vn != 0)
            begin
                den = vn << 18;
                num = theta;
                e.ex = round_sat(num * mag[1], ng[1], den);
                e.ey = round_sat(num * mag[2], ng[2], den);
                e.ez = round_sat(num * mag[3], ng[3], den);
            end
            e.taylor = taylor;
            pending.insert(pending.size(), e);
        endfunction

        function void check_result(err_vec_t got);
            err_vec_t w;
            if (pending.size() == 0)
            begin
                $error("result with no transaction outstanding");
                fails++;
                return;
            end
            w = pending.pop_front();
            if (got.ex !== w.ex)
            begin
                $error("error_x expected %0d actual %0d", w.ex, got.ex);
                fails++;
            end
            if (got.ey !== w.ey)
            begin
                $error("error_y expected %0d actual %0d", w.ey, got.ey);
                fails++;
            end
            if (got.ez !== w.ez)
            begin
                $error("error_z expected %0d actual %0d", w.ez, got.ez);
                fails++;
            end
            if (got.taylor !== w.taylor)
            begin
                $error("small_angle expected %0d actual %0d", w.taylor, got.taylor);
                fails++;
            end
            if (got.degen !== w.degen)
            begin
                $error("degenerate expected %0d actual %0d", w.degen, got.degen);
                fails++;
            end
        endfunction
    endclass

    log_error_scoreboard sb;

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40000000;
        $display("Some tests failed");
        $finish;
    end

    // result side: random stall and compare
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result('{error_x, error_y, error_z, small_angle, degenerate});
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_pair(logic signed [15:0] q[8]);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        desired_w <= q[0]; desired_x <= q[1]; desired_y <= q[2]; desired_z <= q[3];
        current_w <= q[4]; current_x <= q[5]; current_y <= q[6]; current_z <= q[7];
        sb.note_input(q);
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
    endtask

    task automatic write_threshold(logic [15:0] v);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 0;
        sb.threshold = v;
    endtask

    function automatic logic signed [15:0] rand_comp(int shape);
        case (shape)
            0: return 16'($urandom);
            1: return 16'($urandom_range(16384 + 200, 16384 - 200));
            2: return 16'($signed($urandom_range(400)) - 200);
            default: return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    task automatic send_random(int n);
        logic signed [15:0] q[8];
        int kind;
        for (int k = 0; k < n; k++)
        begin
            kind = $urandom_range(9);
            for (int i = 0; i < 8; i++)
                q[i] = rand_comp(0);
            if (kind < 3)
            begin
                // nearly aligned orientations exercise the small angle path
                for (int i = 0; i < 4; i++)
                begin
                    q[i] = (i == 0) ? rand_comp(1) : rand_comp(2);
                    q[i + 4] = q[i] + 16'($signed($urandom_range(6)) - 3);
                end
                if ($urandom_range(1))
                    for (int i = 4; i < 8; i++)
                        q[i] = -q[i];
            end
            else if (kind == 3)
                for (int i = 0; i < 8; i++)
                    q[i] = ($urandom_range(3) == 0) ? rand_comp(3) : rand_comp(2);
            else if (kind == 4)
                for (int i = 0; i < 8; i++)
                    if ($urandom_range(2) == 0)
                        q[i] = 0;
            send_pair(q);
        end
    endtask

    initial
    begin
        logic signed [15:0] q[8];
        logic signed [15:0] ex[4];
        sb = new();
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        in_valid = 0;
        out_ready = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        {desired_w, desired_x, desired_y, desired_z} = '0;
        {current_w, current_x, current_y, current_z} = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: zero product, identity, extremes, opposite and tiny vectors
        ex = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001};
        q = '{0, 0, 0, 0, 16384, 0, 0, 0};
        send_pair(q);
        q = '{16384, 0, 0, 0, 16384, 0, 0, 0};
        send_pair(q);
        q = '{16384, 0, 0, 0, -16384, 0, 0, 0};
        send_pair(q);
        q = '{0, 16384, 0, 0, 16384, 0, 0, 0};
        send_pair(q);
        q = '{16384, 1, 0, 0, 16384, 0, 0, 0};
        send_pair(q);
        q = '{16384, 0, 0, 0, 16384, 0, 0, -1};
        send_pair(q);
        for (int a = 0; a < 4; a++)
        begin
            for (int i = 0; i < 8; i++)
                q[i] = ex[(a + i) % 4];
            send_pair(q);
            for (int i = 0; i < 8; i++)
                q[i] = ex[a];
            send_pair(q);
        end
        q = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
              16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
        send_pair(q);
        drain();

        // zero threshold: a zero vector takes the rotation branch
        write_threshold(16'd0);
        q = '{16384, 0, 0, 0, 16384, 0, 0, 0};
        send_pair(q);
        q = '{12000, 300, -200, 100, 12000, 301, -200, 99};
        send_pair(q);
        send_random(150);
        drain();

        write_threshold(16'hffff);
        send_random(250);
        drain();

        write_threshold(16'd2000);
        send_idle_pct = 68;
        send_random(300);
        // pause the sender until the pipeline has fully emptied
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        recv_stall_pct = 68;
        send_idle_pct = 0;
        send_random(300);
        drain();

        write_threshold(qloe_pkg::THR_RESET);
        send_idle_pct = 26;
        recv_stall_pct = 26;
        send_random(400);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random(400);
        drain();

        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
